>>> rtl/dvtu_pkg.sv
// Package for the distance-vector table block: sizes, codes and shared types.
package dvtu_pkg;

   // table geometry
   localparam int MAX_NODES = 16;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int ADDR_W    = 2 * NODE_W;
   localparam int ENTRIES   = MAX_NODES * MAX_NODES;
   localparam int CNT_W     = NODE_W + 1;
   localparam int DIST_W    = 8;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = CNT_W'(MAX_NODES);

   // operation codes
   localparam logic [1:0] OP_LINK = 2'd0;
   localparam logic [1:0] OP_EXCH = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_NODE_COUNT_ADDR = 3'd0;

   typedef struct packed {
      logic [1:0]        operation;
      logic [NODE_W-1:0] first_node;
      logic [NODE_W-1:0] second_node;
   } req_item_type;

   typedef struct packed {
      logic              entry_known;
      logic [DIST_W-1:0] hop_distance;
      logic [NODE_W-1:0] next_hop;
      logic [CNT_W-1:0]  updated_entries;
      logic              id_error;
   } rsp_result_type;

   // one routing entry as held in the table memory
   typedef struct packed {
      logic              known;
      logic [DIST_W-1:0] distance;
      logic [NODE_W-1:0] hop;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic link_write;
      logic exch_issue;
      logic read_capture;
      logic set_error;
   } dvtu_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] operation;
      logic       bad_id;
      logic       self_item;
      logic       last_dest;
   } dvtu_status_type;

endpackage

>>> rtl/dvtu_ram.sv
// Generic RAM: one write port, two registered read ports.
module dvtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

>>> rtl/dvtu_datapath.sv
// Datapath: item latch, table memory with valid bits, exchange compare stage, result registers.
module dvtu_datapath
   import dvtu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  req_item_type     req_item,
   input  logic [CNT_W-1:0] node_count,
   input  dvtu_cmd_type     cmd,
   output dvtu_status_type  status,
   output rsp_result_type   rsp_result
);

   // entry value of a never written location
   function automatic entry_type reset_entry(input logic [ADDR_W-1:0] addr);
      entry_type e;
      e.known    = (addr[ADDR_W-1:NODE_W] == addr[NODE_W-1:0]);
      e.distance = '0;
      e.hop      = addr[ADDR_W-1:NODE_W];
      return e;
   endfunction

   req_item_type      item_ff;
   logic [CNT_W-1:0]  dest_ff;
   logic              s1_valid_ff;
   logic [ADDR_W-1:0] rd_addr_a_ff;
   logic [ADDR_W-1:0] rd_addr_b_ff;
   logic              vld_a_ff;
   logic              vld_b_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              known_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [NODE_W-1:0] hop_ff;
   logic              error_ff;

   logic [CNT_W-1:0]  cnt_eff;
   logic [ADDR_W-1:0] addr_a;
   logic [ADDR_W-1:0] addr_b;
   logic [$bits(entry_type)-1:0] ram_a;
   logic [$bits(entry_type)-1:0] ram_b;
   entry_type         ent_a;
   entry_type         ent_b;
   logic [DIST_W-1:0] offer;
   logic              take;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;

   // active node count, clamped to the table size
   assign cnt_eff = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;

   // status toward the controller
   assign status.operation = item_ff.operation;
   assign status.bad_id    = ({1'b0, item_ff.first_node} >= cnt_eff) ||
                             ({1'b0, item_ff.second_node} >= cnt_eff);
   assign status.self_item = (item_ff.first_node == item_ff.second_node);
   assign status.last_dest = (CNT_W'(dest_ff + 1'b1) == cnt_eff);

   // read addresses: sender row and receiver row during an exchange, else the read entry
   assign addr_a = cmd.exch_issue ? {item_ff.first_node, dest_ff[NODE_W-1:0]}
                                  : {item_ff.first_node, item_ff.second_node};
   assign addr_b = {item_ff.second_node, dest_ff[NODE_W-1:0]};

   dvtu_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (addr_a),
      .rd_data_a (ram_a),
      .rd_addr_b (addr_b),
      .rd_data_b (ram_b)
   );

   // unwritten locations read as their reset value
   assign ent_a = vld_a_ff ? entry_type'(ram_a) : reset_entry(rd_addr_a_ff);
   assign ent_b = vld_b_ff ? entry_type'(ram_b) : reset_entry(rd_addr_b_ff);

   // exchange compare: saturating offer against the receiver entry
   assign offer = (ent_a.distance == DIST_MAX) ? DIST_MAX : ent_a.distance + 1'b1;
   assign take  = s1_valid_ff && ent_a.known &&
                  (!ent_b.known || (offer < ent_b.distance));

   // single write port: exchange update or new link
   always_comb begin
      wr_en = take || cmd.link_write;
      if (take) begin
         wr_addr          = rd_addr_b_ff;
         wr_data.known    = 1'b1;
         wr_data.distance = offer;
         wr_data.hop      = rd_addr_a_ff[ADDR_W-1:NODE_W];
      end else begin
         wr_addr          = {item_ff.first_node, item_ff.second_node};
         wr_data.known    = 1'b1;
         wr_data.distance = DIST_W'(1);
         wr_data.hop      = item_ff.second_node;
      end
   end

   // control state: valid bits and the compare stage flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.exch_issue;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // payload: item, walk counter, read tags, results
   always_ff @(posedge clock) begin
      rd_addr_a_ff <= addr_a;
      rd_addr_b_ff <= addr_b;
      vld_a_ff     <= valid_ff[addr_a];
      vld_b_ff     <= valid_ff[addr_b];
      if (cmd.load) begin
         item_ff  <= req_item;
         dest_ff  <= '0;
         count_ff <= '0;
         known_ff <= 1'b0;
         dist_ff  <= '0;
         hop_ff   <= '0;
         error_ff <= 1'b0;
      end else begin
         if (cmd.exch_issue) begin
            dest_ff <= CNT_W'(dest_ff + 1'b1);
         end
         if (take) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end
         if (cmd.set_error) begin
            error_ff <= 1'b1;
         end
         if (cmd.read_capture) begin
            known_ff <= ent_a.known;
            dist_ff  <= ent_a.known ? ent_a.distance : '0;
            hop_ff   <= ent_a.known ? ent_a.hop : '0;
         end
      end
   end

   assign rsp_result.entry_known     = known_ff;
   assign rsp_result.hop_distance    = dist_ff;
   assign rsp_result.next_hop        = hop_ff;
   assign rsp_result.updated_entries = count_ff;
   assign rsp_result.id_error        = error_ff;

   // a link write never lands while an exchange compare is pending
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.link_write && s1_valid_ff))
      else $error("link write collides with exchange update");

   // during a walk the update count stays below the table width
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (count_ff < CNT_W'(MAX_NODES)))
      else $error("update count out of range");

endmodule

>>> rtl/dvtu_ctrl.sv
// Controller: sequences decode, link write, entry read and the exchange walk.
module dvtu_ctrl
   import dvtu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  dvtu_status_type status,
   output dvtu_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_EXCH,
      S_DRAIN,
      S_READ,
      S_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (status.operation == OP_NONE) begin
               state_in = S_RESULT;
            end else if (status.bad_id) begin
               cmd.set_error = 1'b1;
               state_in      = S_RESULT;
            end else if (status.operation == OP_LINK) begin
               cmd.link_write = !status.self_item;
               state_in       = S_RESULT;
            end else if (status.operation == OP_READ) begin
               // entry address is presented this cycle, data is back in S_READ
               state_in = S_READ;
            end else begin
               state_in = status.self_item ? S_RESULT : S_EXCH;
            end
         end
         S_EXCH: begin
            cmd.exch_issue = 1'b1;
            if (status.last_dest) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_RESULT;
         end
         S_READ: begin
            cmd.read_capture = 1'b1;
            state_in         = S_RESULT;
         end
         S_RESULT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= (state_in == S_RESULT);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   // an accepted item makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // a result beat lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // the result beat ends the item
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (busy && (state_in == S_IDLE)))
      else $error("result strobe outside the end of an item");

endmodule

>>> rtl/distance_vector_table_update.sv
// Top level of the distance-vector routing table block with its configuration register.
// Sequence: link, error, unused and self exchange items go decode, result; a read goes
// decode, read, result; an exchange walks one destination per cycle, then drain, result.
// Throughput: one item at a time; the next item is accepted the cycle after the result beat.
// Reset: synchronous; clears valid bits so every entry reads its reset value, node_count = 16.
// The result beat is shown for one cycle and the receiver cannot stall it.
module distance_vector_table_update
   import dvtu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   // result channel
   output logic                  rsp_valid,
   output rsp_result_type        rsp_result,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CNT_W-1:0] node_count_ff;
   logic             csr_hit;
   dvtu_cmd_type     cmd;
   dvtu_status_type  status;

   // node count register
   assign csr_hit    = (csr_paddr == CSR_NODE_COUNT_ADDR);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(node_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         node_count_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   dvtu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dvtu_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .node_count (node_count_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_result (rsp_result)
   );

endmodule

>>> tb/distance_vector_table_update_tb.sv
// Self-checking testbench for the distance-vector routing table block.
module distance_vector_table_update_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dvtu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 10;

   // Mirror of the routing tables; predicts one result per accepted item
   class route_table_checker;
      bit                known_tab [MAX_NODES][MAX_NODES];
      logic [DIST_W-1:0] dist_tab  [MAX_NODES][MAX_NODES];
      logic [NODE_W-1:0] hop_tab   [MAX_NODES][MAX_NODES];
      logic [CNT_W-1:0]  node_count;
      rsp_result_type    route_replies_q[$];
      int                faults;

      function new();
         faults     = 0;
         node_count = NODE_COUNT_RESET;
         for (int n = 0; n < MAX_NODES; n++) begin
            for (int d = 0; d < MAX_NODES; d++) begin
               known_tab[n][d] = (n == d);
               dist_tab[n][d]  = '0;
               hop_tab[n][d]   = NODE_W'(n);
            end
         end
      endfunction

      function void set_node_count(logic [CNT_W-1:0] value);
         node_count = value;
      endfunction

      function void fault(string msg);
         faults++;
         if (faults <= 10) begin
            $display("%0t: mismatch: %s", $realtime, msg);
         end
      endfunction

      function string show(rsp_result_type r);
         return $sformatf("known=%0d dist=%0d hop=%0d updated=%0d err=%0d", r.entry_known,
                          r.hop_distance, r.next_hop, r.updated_entries, r.id_error);
      endfunction

      // apply one item to the mirrored tables and queue its answer
      function void note_item(req_item_type it);
         rsp_result_type answer;
         int unsigned    active;
         int unsigned    a;
         int unsigned    b;
         int unsigned    offer;
         int unsigned    changed;
         answer  = '0;
         a       = it.first_node;
         b       = it.second_node;
         changed = 0;
         active  = (node_count > MAX_NODES) ? MAX_NODES : node_count;
         if (it.operation == OP_NONE) begin
            // unused code: all fields zero, ids not checked
         end else if (a >= active || b >= active) begin
            answer.id_error = 1'b1;
         end else begin
            case (it.operation)
               OP_LINK: begin
                  // self link is dropped silently
                  if (a != b) begin
                     known_tab[a][b] = 1'b1;
                     dist_tab[a][b]  = 8'd1;
                     hop_tab[a][b]   = NODE_W'(b);
                  end
               end
               OP_EXCH: begin
                  if (a != b) begin
                     for (int d = 0; d < active; d++) begin
                        if (!known_tab[a][d]) continue;
                        offer = dist_tab[a][d] + 1;
                        if (offer > DIST_MAX) offer = DIST_MAX;
                        if (!known_tab[b][d] || offer < dist_tab[b][d]) begin
                           known_tab[b][d] = 1'b1;
                           dist_tab[b][d]  = DIST_W'(offer);
                           hop_tab[b][d]   = NODE_W'(a);
                           changed++;
                        end
                     end
                  end
                  answer.updated_entries = CNT_W'(changed);
               end
               default: begin
                  // unknown entry reads back as all zero
                  if (known_tab[a][b]) begin
                     answer.entry_known  = 1'b1;
                     answer.hop_distance = dist_tab[a][b];
                     answer.next_hop     = hop_tab[a][b];
                  end
               end
            endcase
         end
         route_replies_q = {route_replies_q, answer};
      endfunction

      function void check_result(rsp_result_type got);
         rsp_result_type want;
         if (route_replies_q.size() == 0) begin
            fault($sformatf("result beat with nothing pending: %s", show(got)));
            return;
         end
         want = route_replies_q.pop_front();
         if (got.entry_known !== want.entry_known || got.hop_distance !== want.hop_distance ||
             got.next_hop !== want.next_hop || got.updated_entries !== want.updated_entries ||
             got.id_error !== want.id_error) begin
            fault($sformatf("want %s, got %s", show(want), show(got)));
         end
      endfunction

      function void close_out();
         if (route_replies_q.size() != 0) begin
            fault($sformatf("%0d results never arrived", route_replies_q.size()));
         end
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic                  busy;
   req_item_type          req_item    = '0;
   logic                  rsp_valid;
   rsp_result_type        rsp_result;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   route_table_checker routes;
   int items_sent   = 0;
   int results_seen = 0;
   int idle_cycles  = 0;
   int no_gap_left  = 0;
   bit start_high   = 1'b0;
   int phase_counts [PHASES] = '{16, 1, 9, 31, 2, 0, 16, 13, 17, 5};

   distance_vector_table_update DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_result  (rsp_result),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Monitor: pre-edge values of both channels, plus the stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            routes.note_item(req_item);
         end
         if (rsp_valid === 1'b1) begin
            routes.check_result(rsp_result);
            results_seen++;
         end
         if ((start && !busy) || rsp_valid === 1'b1) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("distance_vector_table_update_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic lower_start();
      if (start_high) begin
         start      <= 1'b0;
         start_high  = 1'b0;
      end
   endtask

   // one command beat; start stays high afterwards unless a gap follows
   task automatic issue_item(req_item_type it);
      int gap;
      if (no_gap_left > 0) begin
         gap = 0;
         no_gap_left--;
      end else begin
         gap = $urandom_range(0, 8);
         if ($urandom_range(0, 29) == 0) no_gap_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         lower_start();
         repeat (gap) @(posedge clock);
      end
      req_item   <= it;
      start      <= 1'b1;
      start_high  = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_op(logic [1:0] op, int a, int b);
      req_item_type it;
      it.operation   = op;
      it.first_node  = NODE_W'(a);
      it.second_node = NODE_W'(b);
      issue_item(it);
   endtask

   // hold off until every outstanding result beat has come back
   task automatic drain();
      lower_start();
      do @(posedge clock); while (results_seen != items_sent);
   endtask

   // write node_count, then read it back
   task automatic write_node_count(logic [CSR_DATA_W-1:0] value);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_NODE_COUNT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      routes.set_node_count(value[CNT_W-1:0]);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(value[CNT_W-1:0])) begin
         routes.fault($sformatf("node_count reads %0d, wrote %0d", csr_prdata,
                                value[CNT_W-1:0]));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_item_type random_route_item(int active);
      req_item_type it;
      int           pick;
      pick = $urandom_range(0, 99);
      it.operation = (pick < 30) ? OP_LINK : (pick < 65) ? OP_EXCH :
                     (pick < 95) ? OP_READ : OP_NONE;
      // mostly valid ids, some out of range
      if (active == 0 || $urandom_range(0, 9) == 0) begin
         it.first_node  = NODE_W'($urandom_range(0, MAX_NODES - 1));
         it.second_node = NODE_W'($urandom_range(0, MAX_NODES - 1));
      end else begin
         it.first_node  = NODE_W'($urandom_range(0, active - 1));
         it.second_node = NODE_W'($urandom_range(0, active - 1));
      end
      return it;
   endfunction

   initial begin
      int active;
      int count;
      routes = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: full table
      write_node_count(32'd16);
      send_op(OP_READ, 0, 0);
      send_op(OP_READ, 15, 15);
      send_op(OP_READ, 0, 15);
      send_op(OP_LINK, 0, 1);
      send_op(OP_LINK, 1, 2);
      send_op(OP_LINK, 3, 3);
      send_op(OP_READ, 3, 3);
      send_op(OP_EXCH, 1, 0);
      send_op(OP_READ, 0, 2);
      send_op(OP_EXCH, 0, 15);
      send_op(OP_READ, 15, 2);
      send_op(OP_EXCH, 4, 4);
      send_op(OP_NONE, 15, 15);
      send_op(OP_LINK, 15, 0);
      send_op(OP_EXCH, 15, 0);
      send_op(OP_LINK, 0, 2);
      send_op(OP_READ, 0, 2);
      send_op(OP_EXCH, 15, 14);
      send_op(OP_READ, 14, 0);

      // directed: id errors on a small table, upper pwdata bits ignored
      write_node_count(32'hFFFF_FFE5);
      send_op(OP_LINK, 5, 0);
      send_op(OP_EXCH, 0, 15);
      send_op(OP_READ, 4, 4);
      send_op(OP_NONE, 15, 15);

      // directed: empty table and oversized count
      write_node_count(32'd0);
      send_op(OP_READ, 0, 0);
      send_op(OP_LINK, 0, 1);
      write_node_count(32'd31);
      send_op(OP_LINK, 15, 14);
      send_op(OP_EXCH, 15, 13);
      send_op(OP_READ, 13, 14);

      // random phases over several table sizes
      for (int p = 0; p < PHASES; p++) begin
         write_node_count(CSR_DATA_W'(phase_counts[p]));
         active = (phase_counts[p] > MAX_NODES) ? MAX_NODES : phase_counts[p];
         count  = (active == 0) ? 20 : 140;
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 39) == 0) drain();
            issue_item(random_route_item(active));
         end
      end

      drain();
      repeat (40) @(posedge clock);
      routes.close_out();
      if (routes.faults == 0) begin
         $display("distance_vector_table_update_tb: PASS");
      end else begin
         $display("distance_vector_table_update_tb: FAIL");
      end
      $finish;
   end

endmodule
